@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ARB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ARB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/arb_pkg.sv @@
// Types, constants and register codes of the angular range binning block.
`timescale 1ns / 1ps

package arb_pkg;

    // Bin store geometry
    localparam int MAX_BINS = 1024;
    localparam int BIN_AW   = $clog2(MAX_BINS);

    // Angle constants in 1/64 degree
    localparam logic [14:0] FULL_TURN_Q6 = 15'd23040;
    localparam logic [14:0] SCAN_WRAP_Q6 = 15'd640;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH      = 3'd4;

    localparam logic [14:0] RST_BIN_WIDTH    = 15'd64;
    localparam logic [14:0] RST_ANGLE_OFFSET = 15'd0;
    localparam logic [5:0]  RST_QUALITY_THR  = 6'd10;
    localparam logic [13:0] RST_MIN_DISTANCE = 14'd10;
    localparam logic [15:0] RST_REFRESH      = 16'd500;

    // Item modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Divider length: one quotient bit per step
    localparam int DIV_W  = 15;
    localparam int DIV_CW = $clog2(DIV_W);

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  quality;
        logic        check_bit;
        logic        start_bit;
        logic [14:0] angle_q6;
        logic [13:0] distance_mm;
        logic [9:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        scan_complete;
        logic [9:0]  bin_index;
        logic [13:0] range_mm;
        logic        trimmed;
    } t_out_item;

    // One bin of the store
    typedef struct packed {
        logic [13:0] range_mm;
        logic [31:0] stamp_ms;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ hdl/arb_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module arb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/arb_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module arb_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arb_pkg::t_div_req  i_req,
    output arb_pkg::t_div_rsp  o_rsp
);

    logic [arb_pkg::DIV_W-1:0]  r_rem;
    logic [arb_pkg::DIV_W-1:0]  r_quo;
    logic [arb_pkg::DIV_W-1:0]  r_dvs;
    logic [arb_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [arb_pkg::DIV_W:0]    trial;
    logic [arb_pkg::DIV_W:0]    diff;
    logic                       fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[arb_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    // Control: start, count steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= arb_pkg::DIV_CW'(arb_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[arb_pkg::DIV_W-1:0] : trial[arb_pkg::DIV_W-1:0];
            r_quo <= {r_quo[arb_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ hdl/angular_range_binning_with_aging.sv @@
// Top level: lidar sample binning by bearing with aging of stale bins.
//
// Input channel: i_in_valid / o_in_stall carry one item per beat (sample,
// tick or read, chosen by the mode field). Output channel: o_out_valid /
// i_out_stall carry exactly one result beat per item, in item order.
// Configuration: i_cfg_wen writes i_cfg_data into register i_cfg_index on
// the clock edge; write only while the block is idle.
// Items are handled one at a time; the result beat appears in the same cycle
// in which the next item can be taken. A sample first reduces its bearing by
// whole turns, then runs the iterative divider for the bin index, then the
// trim check. A sample that triggers a trim adds a sweep in which every bin
// is read and each stale bin is written back with a zero range through the
// single pair of RAM ports.
// Results sit in an output register, so the next item is taken while a
// result still waits for the receiver; a stalled receiver holds the last
// result and the block stops only when a second result is ready.
// Reset clears the control state and then runs a clearing pass over every
// bin of the store, one bin a cycle, with o_in_stall high.
`timescale 1ns / 1ps

module angular_range_binning_with_aging (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  arb_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output arb_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_wen,
    input  logic [arb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = arb_pkg::BIN_AW;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_TRIM  = 4'd4;
    localparam logic [3:0] ST_SWEEP = 4'd5;
    localparam logic [3:0] ST_READ  = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    localparam logic [AW:0]  BINS_CNT = (AW + 1)'(arb_pkg::MAX_BINS);
    localparam logic [15:0]  BINS_W16 = 16'(arb_pkg::MAX_BINS);

    logic [3:0]          r_state;
    logic [AW:0]         r_cnt;
    logic                r_pend;
    logic [AW-1:0]       r_waddr;
    arb_pkg::t_in_item   r_item;
    logic                r_ok;
    logic [15:0]         r_sum;
    arb_pkg::t_out_item  r_res;
    arb_pkg::t_out_item  r_out;
    logic                r_out_valid;

    logic [14:0]         r_bin_width;
    logic [14:0]         r_angle_offset;
    logic [5:0]          r_quality_thr;
    logic [13:0]         r_min_distance;
    logic [15:0]         r_refresh;

    logic [31:0]         r_now;
    logic [31:0]         r_last_trim;
    logic [14:0]         r_last_bearing;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    arb_pkg::t_entry     ram_wdata;
    logic [AW-1:0]       ram_raddr;
    arb_pkg::t_entry     ram_rdata;

    arb_pkg::t_div_req   div_req;
    arb_pkg::t_div_rsp   div_rsp;

    logic                in_take;
    logic                out_free;
    logic                sample_ok;
    logic                idx_ok;
    logic [14:0]         bearing;
    logic                trim_due;
    logic                stale;
    logic                sw_issue;

    // Qualify an incoming sample
    assign sample_ok = (i_in_data.quality > r_quality_thr) && i_in_data.check_bit
                       && i_in_data.start_bit
                       && (i_in_data.angle_q6 < arb_pkg::FULL_TURN_Q6)
                       && (i_in_data.distance_mm > r_min_distance);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign bearing  = r_sum[14:0];
    assign idx_ok   = r_ok && ({1'b0, div_rsp.quot} < BINS_W16);
    assign trim_due = {1'b0, r_now} > ({1'b0, r_last_trim} + {17'd0, r_refresh});
    assign stale    = {1'b0, r_now} > ({1'b0, ram_rdata.stamp_ms} + {17'd0, r_refresh});
    assign sw_issue = (r_cnt < BINS_CNT);

    // Divider request: start once the bearing is reduced
    assign div_req.start    = (r_state == ST_MOD) && (r_sum < {1'b0, arb_pkg::FULL_TURN_Q6});
    assign div_req.dividend = r_sum[14:0];
    assign div_req.divisor  = (r_bin_width == '0) ? 15'd1 : r_bin_width;

    arb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // RAM port steering: clear, sample store, sweep write-back; reads
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = '0;
        ram_raddr = r_cnt[AW-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                ram_raddr = AW'(i_in_data.read_index);
            end
            ST_DIV: begin
                ram_we             = div_rsp.done && idx_ok;
                ram_waddr          = AW'(div_rsp.quot);
                ram_wdata.range_mm = r_item.distance_mm;
                ram_wdata.stamp_ms = r_now;
            end
            ST_SWEEP: begin
                ram_we             = r_pend && stale;
                ram_waddr          = r_waddr;
                ram_wdata.range_mm = '0;
                ram_wdata.stamp_ms = ram_rdata.stamp_ms;
            end
            default: begin
            end
        endcase
    end

    arb_ram #(
        .WIDTH ($bits(arb_pkg::t_entry)),
        .DEPTH (arb_pkg::MAX_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width    <= arb_pkg::RST_BIN_WIDTH;
            r_angle_offset <= arb_pkg::RST_ANGLE_OFFSET;
            r_quality_thr  <= arb_pkg::RST_QUALITY_THR;
            r_min_distance <= arb_pkg::RST_MIN_DISTANCE;
            r_refresh      <= arb_pkg::RST_REFRESH;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                arb_pkg::REG_BIN_WIDTH:    r_bin_width    <= i_cfg_data[14:0];
                arb_pkg::REG_ANGLE_OFFSET: r_angle_offset <= i_cfg_data[14:0];
                arb_pkg::REG_QUALITY_THR:  r_quality_thr  <= i_cfg_data[5:0];
                arb_pkg::REG_MIN_DISTANCE: r_min_distance <= i_cfg_data[13:0];
                arb_pkg::REG_REFRESH:      r_refresh      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and state of the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_cnt          <= '0;
            r_pend         <= 1'b0;
            r_now          <= '0;
            r_last_trim    <= '0;
            r_last_bearing <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == BINS_CNT - 1'b1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_take) begin
                        unique case (i_in_data.mode)
                            arb_pkg::MODE_SAMPLE: r_state <= ST_MOD;
                            arb_pkg::MODE_TICK: begin
                                r_now   <= r_now + 1'b1;
                                r_state <= ST_DONE;
                            end
                            arb_pkg::MODE_READ:   r_state <= ST_READ;
                            default:              r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_MOD: begin
                    if (div_req.start) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        if (idx_ok) begin
                            r_last_bearing <= bearing;
                        end
                        r_state <= ST_TRIM;
                    end
                end
                ST_TRIM: begin
                    if (trim_due) begin
                        r_last_trim <= r_now;
                        r_cnt       <= '0;
                        r_pend      <= 1'b0;
                        r_state     <= ST_SWEEP;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_SWEEP: begin
                    // Issue the next read while the previous bin, if stale, is written back
                    r_pend  <= sw_issue;
                    r_waddr <= r_cnt[AW-1:0];
                    if (sw_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_pend) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_READ: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Item datapath: latch the beat, reduce the bearing, build the result
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_data;
            r_ok   <= sample_ok;
            r_sum  <= {1'b0, i_in_data.angle_q6} + {1'b0, r_angle_offset};
            // Start from an empty result; a sample echoes its distance, a read its bin
            r_res.accepted      <= 1'b0;
            r_res.scan_complete <= 1'b0;
            r_res.trimmed       <= 1'b0;
            r_res.range_mm      <= (i_in_data.mode == arb_pkg::MODE_SAMPLE)
                                   ? i_in_data.distance_mm : 14'd0;
            r_res.bin_index     <= (i_in_data.mode == arb_pkg::MODE_READ)
                                   ? i_in_data.read_index : 10'd0;
        end
        if ((r_state == ST_MOD) && !div_req.start) begin
            r_sum <= r_sum - {1'b0, arb_pkg::FULL_TURN_Q6};
        end
        if ((r_state == ST_DIV) && div_rsp.done && idx_ok) begin
            r_res.accepted      <= 1'b1;
            r_res.bin_index     <= div_rsp.quot[9:0];
            r_res.scan_complete <= (bearing < r_last_bearing)
                                   && (bearing < arb_pkg::SCAN_WRAP_Q6);
        end
        if ((r_state == ST_TRIM) && trim_due) begin
            r_res.trimmed <= 1'b1;
        end
        if (r_state == ST_READ) begin
            r_res.range_mm <= ({22'd0, r_item.read_index} < 32'(arb_pkg::MAX_BINS))
                              ? ram_rdata.range_mm : 14'd0;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/arb_checker.sv @@
// Port-level checker for the binning block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input arb_pkg::t_out_item o_out_data
);

    // Hold a stalled result beat
    `ARB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `ARB_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))

    // A scan wrap is only reported for a stored sample
    `ARB_ASSERT_NOW(a_wrap_stored, o_out_valid && o_out_data.scan_complete, o_out_data.accepted)

    // A stored sample is always above the minimum distance, so never zero
    `ARB_ASSERT_NOW(a_stored_range, o_out_valid && o_out_data.accepted, o_out_data.range_mm != '0)

endmodule

bind angular_range_binning_with_aging arb_checker u_arb_checker (.*);

@@ tb/sv/angular_range_binning_with_aging_tb.sv @@
// Self-checking testbench for the angular range binning block with bin aging.
`timescale 1ns / 1ps

module angular_range_binning_with_aging_tb;
    import arb_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 9;
    // Longest quiet stretch: reset clearing pass, a full sweep, the long hold-off
    localparam int QUIET_LIMIT   = 20000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_BEAT  = 700;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 32;
    localparam int RAND_PHASES   = 8;

    // The fourth mode code carries no operation
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Items waiting to be driven and results waiting to be seen
    t_in_item  lidar_items [$];
    t_out_item bin_results_due [$];

    // Shadow copy of the bin store, time base and registers
    logic [13:0] shadow_range [MAX_BINS];
    logic [31:0] shadow_stamp [MAX_BINS];
    logic [31:0] clock_ms;
    logic [31:0] trim_ms;
    logic [14:0] prev_bearing;
    logic [14:0] cur_width;
    logic [14:0] cur_offset;
    logic [5:0]  cur_qual_thr;
    logic [13:0] cur_min_dist;
    logic [15:0] cur_refresh;

    int   gap_left   = 0;
    int   stall_left = 0;
    int   rx_beats   = 0;
    bit   long_hold_done = 1'b0;
    bit   quiet_tail = 1'b0;
    int   n_items    = 0;
    int   n_results  = 0;
    int   n_stored   = 0;
    int   n_wraps    = 0;
    int   n_sweeps   = 0;
    int   n_reads    = 0;
    int   n_settings = 0;
    int   n_fail     = 0;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    angular_range_binning_with_aging u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Work out the result of one item and advance the shadow state
    function automatic t_out_item predict_bin_result(t_in_item it);
        t_out_item   res;
        logic [15:0] sum;
        logic [14:0] bearing;
        logic [14:0] width;
        int unsigned slot;
        int          b;
        res = '0;
        case (it.mode)
            MODE_SAMPLE: begin
                res.range_mm = it.distance_mm;
                if (it.quality > cur_qual_thr && it.check_bit && it.start_bit &&
                    it.angle_q6 < FULL_TURN_Q6 && it.distance_mm > cur_min_dist) begin
                    sum     = 16'(it.angle_q6) + 16'(cur_offset);
                    bearing = 15'(sum % 16'(FULL_TURN_Q6));
                    width   = (cur_width == '0) ? 15'd1 : cur_width;
                    slot    = 32'(bearing / width);
                    // bins past the end of the store drop the sample
                    if (slot < MAX_BINS) begin
                        shadow_range[slot[9:0]] = it.distance_mm;
                        shadow_stamp[slot[9:0]] = clock_ms;
                        res.accepted       = 1'b1;
                        res.bin_index      = slot[9:0];
                        res.scan_complete  = (bearing < prev_bearing) &&
                                             (bearing < SCAN_WRAP_Q6);
                        prev_bearing       = bearing;
                        n_stored++;
                        if (res.scan_complete)
                            n_wraps++;
                    end
                end
                // Sweep stale bins once the refresh interval has run out
                if ({1'b0, clock_ms} > {1'b0, trim_ms} + 33'(cur_refresh)) begin
                    for (b = 0; b < MAX_BINS; b++) begin
                        if ({1'b0, clock_ms} > {1'b0, shadow_stamp[b[9:0]]} + 33'(cur_refresh))
                            shadow_range[b[9:0]] = '0;
                    end
                    trim_ms     = clock_ms;
                    res.trimmed = 1'b1;
                    n_sweeps++;
                end
            end
            MODE_TICK: begin
                clock_ms = clock_ms + 32'd1;
            end
            MODE_READ: begin
                res.bin_index = it.read_index;
                res.range_mm  = shadow_range[it.read_index];
                n_reads++;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item sample_item(input logic [5:0] q, input logic chk,
                                             input logic st, input logic [14:0] ang,
                                             input logic [13:0] range_in);
        t_in_item it;
        it             = random_item();
        it.mode        = MODE_SAMPLE;
        it.quality     = q;
        it.check_bit   = chk;
        it.start_bit   = st;
        it.angle_q6    = ang;
        it.distance_mm = range_in;
        return it;
    endfunction

    function automatic t_in_item read_item(input logic [9:0] idx);
        t_in_item it;
        it            = random_item();
        it.mode       = MODE_READ;
        it.read_index = idx;
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // Offer items from the queue; predict each one as its beat is taken
    always @(posedge i_clk) begin : item_driver
        bit holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            holding = i_in_valid && o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                bin_results_due.push_back(predict_bin_result(i_in_data));
                n_items++;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (lidar_items.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= lidar_items.pop_front();
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 8);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Hold off the result channel in short bursts, and once for a long stretch
    always @(posedge i_clk) begin : result_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall)
                rx_beats++;
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!long_hold_done && rx_beats >= HOLD_AT_BEAT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (bin_results_due.size() == 0) begin
                $error("result beat with no item outstanding: %h", o_out_data);
                n_fail++;
            end else begin
                want = bin_results_due.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(o_out_data.accepted));
                check_field("scan_complete", 32'(want.scan_complete),
                            32'(o_out_data.scan_complete));
                check_field("bin_index", 32'(want.bin_index), 32'(o_out_data.bin_index));
                check_field("range_mm", 32'(want.range_mm), 32'(o_out_data.range_mm));
                check_field("trimmed", 32'(want.trimmed), 32'(o_out_data.trimmed));
                n_results++;
            end
        end
    end

    // End the run if no beat moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, bin_results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Write all five registers on consecutive edges and mirror them
    task automatic write_settings(input logic [14:0] width, input logic [14:0] offset,
                                  input logic [5:0] thr, input logic [13:0] min_dist,
                                  input logic [15:0] refresh);
        logic [CFG_IDX_W-1:0]  ids  [5];
        logic [CFG_DATA_W-1:0] vals [5];
        int r;
        ids[0] = REG_BIN_WIDTH;    vals[0] = 16'(width);
        ids[1] = REG_ANGLE_OFFSET; vals[1] = 16'(offset);
        ids[2] = REG_QUALITY_THR;  vals[2] = 16'(thr);
        ids[3] = REG_MIN_DISTANCE; vals[3] = 16'(min_dist);
        ids[4] = REG_REFRESH;      vals[4] = refresh;
        for (r = 0; r < 5; r++) begin
            @(posedge i_clk);
            i_cfg_wen   <= 1'b1;
            i_cfg_index <= ids[r[2:0]];
            i_cfg_data  <= vals[r[2:0]];
        end
        @(posedge i_clk);
        i_cfg_wen    <= 1'b0;
        cur_width    = width;
        cur_offset   = offset;
        cur_qual_thr = thr;
        cur_min_dist = min_dist;
        cur_refresh  = refresh;
        n_settings++;
        @(negedge i_clk);
    endtask

    // Wait until every item is taken and every result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        while (lidar_items.size() != 0 || i_in_valid || bin_results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Queue mostly well-formed scans, with ticks, reads and noise mixed in
    task automatic queue_random(input int count, input int tick_pct);
        t_in_item    it;
        int          pick;
        int          n;
        int unsigned scan_pos;
        int unsigned step;
        int unsigned width_eff;
        int unsigned off_m;
        scan_pos  = $urandom_range(0, 639);
        step      = $urandom_range(300, 2500);
        width_eff = (cur_width == '0) ? 1 : 32'(cur_width);
        off_m     = 32'(cur_offset % FULL_TURN_Q6);
        for (n = 0; n < count; n++) begin
            it   = random_item();
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) begin
                it.mode = MODE_TICK;
            end else if (pick < tick_pct + 10) begin
                it.mode = MODE_READ;
                // half the reads look at the bin the scan is passing over
                if ($urandom_range(0, 1) == 1)
                    it.read_index = (scan_pos / width_eff > 1023) ? 10'd1023 :
                                    10'(scan_pos / width_eff);
            end else if (pick == 99) begin
                it.mode = MODE_UNUSED;
            end else if (pick >= 89) begin
                it.mode = MODE_SAMPLE;
            end else begin
                it.mode       = MODE_SAMPLE;
                it.quality    = (cur_qual_thr == 6'd63) ? 6'd63 :
                                6'($urandom_range(cur_qual_thr + 1, 63));
                it.check_bit  = 1'b1;
                it.start_bit  = 1'b1;
                it.angle_q6   = 15'((scan_pos + FULL_TURN_Q6 - off_m) % FULL_TURN_Q6);
                if (cur_min_dist == 14'd16383)
                    it.distance_mm = 14'd16383;
                else if ($urandom_range(0, 7) == 0)
                    it.distance_mm = cur_min_dist + 14'd1;
                else
                    it.distance_mm = 14'($urandom_range(cur_min_dist + 1, 16383));
                // advance the bearing; start a new scan after a full turn
                scan_pos += step;
                if (scan_pos >= FULL_TURN_Q6) begin
                    scan_pos = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 639) :
                                                            $urandom_range(0, 23039);
                    step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) :
                                                        $urandom_range(300, 2500);
                end
            end
            lidar_items.push_back(it);
        end
    endtask

    initial begin : stimulus
        t_in_item    it;
        int          k;
        logic [14:0] w;
        logic [5:0]  thr;
        logic [13:0] mind;
        logic [15:0] refr;

        for (k = 0; k < MAX_BINS; k++) begin
            shadow_range[k[9:0]] = '0;
            shadow_stamp[k[9:0]] = '0;
        end
        clock_ms     = '0;
        trim_ms      = '0;
        prev_bearing = '0;
        cur_width    = RST_BIN_WIDTH;
        cur_offset   = RST_ANGLE_OFFSET;
        cur_qual_thr = RST_QUALITY_THR;
        cur_min_dist = RST_MIN_DISTANCE;
        cur_refresh  = RST_REFRESH;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset settings
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd0, 14'd16383));
        lidar_items.push_back(sample_item(6'd11, 1'b1, 1'b1, 15'd23039, 14'd11));
        // bearing drops under ten degrees: scan complete
        lidar_items.push_back(sample_item(6'd40, 1'b1, 1'b1, 15'd100, 14'd500));
        // quality at threshold, zero quality, check bit, start flag
        lidar_items.push_back(sample_item(6'd10, 1'b1, 1'b1, 15'd5000, 14'd900));
        lidar_items.push_back(sample_item(6'd0, 1'b1, 1'b1, 15'd5000, 14'd900));
        lidar_items.push_back(sample_item(6'd63, 1'b0, 1'b1, 15'd5000, 14'd900));
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b0, 15'd5000, 14'd900));
        // angle at and above a full turn
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd23040, 14'd900));
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd32767, 14'd900));
        // distance at the minimum, and zero
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd5000, 14'd10));
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd5000, 14'd0));
        // a rise, a drop that stays above ten degrees, then one below it
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd700, 14'd1234));
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd650, 14'd4321));
        lidar_items.push_back(sample_item(6'd63, 1'b1, 1'b1, 15'd639, 14'd77));
        lidar_items.push_back(read_item(10'd0));
        lidar_items.push_back(read_item(10'd359));
        lidar_items.push_back(read_item(10'd9));
        lidar_items.push_back(read_item(10'd10));
        lidar_items.push_back(read_item(10'd78));
        lidar_items.push_back(read_item(10'd1023));
        it = random_item();
        it.mode = MODE_TICK;
        lidar_items.push_back(it);
        it = '1;
        it.mode = MODE_UNUSED;
        lidar_items.push_back(it);
        lidar_items.push_back('0);
        wait_idle();

        // Zero width, open thresholds, sweep on every sample after a tick
        write_settings(15'd0, 15'd0, 6'd0, 14'd0, 16'd0);
        queue_random(150, 15);
        wait_idle();

        // One bin for the whole turn, offset past a full turn, no aging
        write_settings(15'd23040, 15'd32767, 6'd0, 14'd0, 16'd65535);
        queue_random(60, 10);
        wait_idle();

        // Nothing passes the thresholds; sweeps still run
        write_settings(15'd1, 15'd23039, 6'd63, 14'd16383, 16'd1);
        queue_random(60, 20);
        wait_idle();

        for (k = 0; k < RAND_PHASES; k++) begin
            case ($urandom_range(0, 3))
                0:       w = 15'($urandom_range(1, 8));
                1:       w = 15'd23;
                2:       w = 15'($urandom_range(16, 90));
                default: w = 15'($urandom_range(91, 23040));
            endcase
            thr  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                                                 6'($urandom_range(0, 20));
            mind = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383)) :
                                                 14'($urandom_range(0, 300));
            refr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                                 16'($urandom_range(0, 40));
            write_settings(w, 15'($urandom_range(0, 23039)), thr, mind, refr);
            queue_random(200, 15);
            wait_idle();
        end

        // Closing stretch at full rate on both channels
        quiet_tail = 1'b1;
        write_settings(RST_BIN_WIDTH, RST_ANGLE_OFFSET, RST_QUALITY_THR,
                       RST_MIN_DISTANCE, 16'd2);
        queue_random(100, 15);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bin_results_due.size() != 0) begin
            $error("%0d results never arrived", bin_results_due.size());
            n_fail++;
        end
        $display("Covered %0d items over %0d register settings: %0d samples binned,",
                 n_items, n_settings + 1, n_stored);
        $display("%0d scan wraps, %0d stale-bin sweeps, %0d bin reads, %0d results checked.",
                 n_wraps, n_sweeps, n_reads, n_results);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/arb_pkg.sv
hdl/arb_ram.sv
hdl/arb_div.sv
hdl/angular_range_binning_with_aging.sv
hdl/arb_checker.sv
tb/sv/angular_range_binning_with_aging_tb.sv
